// File: design/aging_device_address_table_core_macros.svh
// ----------------------------------------------------------------------------
// aging_device_address_table_core_macros.svh
// Assertion macros used by the checker of the address table.
// ----------------------------------------------------------------------------
`ifndef AGING_DEVICE_ADDRESS_TABLE_CORE_MACROS_SVH
`define AGING_DEVICE_ADDRESS_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define ADT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define ADT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/adt_pkg.sv
// ----------------------------------------------------------------------------
// adt_pkg
// Types, codes and constants of the aging device address table.
// ----------------------------------------------------------------------------
package adt_pkg;

   // Table size default and index width (covers up to 64 entries)
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int IDX_W             = 6;
   localparam logic [7:0] AGE_LIMIT_RESET = 8'd120;
   localparam logic [7:0] AGE_MAX         = 8'hFF;

   // Command codes
   localparam logic [1:0] CMD_LEARN  = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   // Request beat
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] dev_number;
      logic [15:0] net_address;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_address;
   } rsp_type;

   // Operation token walking down the row of cells
   typedef struct packed {
      logic             valid;
      logic [1:0]       cmd;
      logic [15:0]      num;
      logic [15:0]      addr;
      logic             matched;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic [15:0]      found_addr;
   } token_type;

   // Deferred fill of the lowest free slot after a learn miss
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [15:0]      num;
      logic [15:0]      addr;
   } fill_type;

endpackage

// File: design/adt_cell.sv
// ----------------------------------------------------------------------------
// adt_cell
// One table slot: holds number, address and age, acts on the passing token
// and hands the token on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module adt_cell
   import adt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  logic [7:0]       age_limit,
   input  token_type        tok_in,
   input  fill_type         fill,
   output token_type        tok_out
);

   logic [15:0] num_ff,  num_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  age_ff,  age_in;
   token_type   tok_ff,  tok_next_in;

   logic        occupied;
   logic        hit;
   logic [7:0]  age_inc;

   assign occupied = (num_ff != 16'd0);
   assign hit      = occupied && (num_ff == tok_in.num);
   assign age_inc  = (age_ff == AGE_MAX) ? AGE_MAX : age_ff + 8'd1;

   // Slot update and token hand-on
   always_comb begin
      num_in      = num_ff;
      addr_in     = addr_ff;
      age_in      = age_ff;
      tok_next_in = tok_in;
      if (tok_in.valid) begin
         case (tok_in.cmd)
            CMD_LEARN: begin
               if (hit) begin
                  addr_in             = tok_in.addr;
                  age_in              = 8'd0;
                  tok_next_in.matched = 1'b1;
               end
               if (!occupied && !tok_in.free_found) begin
                  tok_next_in.free_found = 1'b1;
                  tok_next_in.free_idx   = cell_index;
               end
            end
            CMD_LOOKUP: begin
               if (hit) begin
                  tok_next_in.matched    = 1'b1;
                  tok_next_in.found_addr = addr_ff;
               end
            end
            CMD_TICK: begin
               if (occupied) begin
                  if (age_inc > age_limit) begin
                     num_in  = 16'd0;
                     addr_in = 16'd0;
                     age_in  = 8'd0;
                  end else begin
                     age_in = age_inc;
                  end
               end
            end
            default: begin
               num_in  = 16'd0;
               addr_in = 16'd0;
               age_in  = 8'd0;
            end
         endcase
      end
      // Fill of the lowest free slot, issued once the token has left the row
      if (fill.en && (fill.idx == cell_index)) begin
         num_in  = fill.num;
         addr_in = fill.addr;
         age_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= 16'd0;
         addr_ff <= 16'd0;
         age_ff  <= 8'd0;
      end else begin
         num_ff  <= num_in;
         addr_ff <= addr_in;
         age_ff  <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: design/aging_device_address_table_core.sv
// ----------------------------------------------------------------------------
// aging_device_address_table_core
// Device number to network address table with per-entry ageing.
// ----------------------------------------------------------------------------
// Each accepted command walks a row of TABLE_ENTRIES slot cells, one cell per
// cycle, and its response strobe is registered from the token leaving the last
// cell; busy drops in the strobe cycle, where the next start is taken, so a new
// command is taken only once the last one is through. The strobe lasts one
// cycle and cannot be held off: capture it when it shows. A learn that misses
// fills the lowest free slot, if any, as the walk ends. The table is empty
// straight out of reset, the age limit reads 120 and csr writes are always
// ready; the user must keep them to an idle block, which is not enforced.
// ----------------------------------------------------------------------------
module aging_device_address_table_core
   import adt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic       busy_ff;
   logic       rsp_strobe_ff;
   rsp_type    rsp_ff, rsp_in;
   logic [7:0] age_limit_ff;

   token_type  tok [TABLE_ENTRIES+1];
   token_type  tail;
   fill_type   fill;
   logic       accept;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   // Token injected into the first cell on an accepted start beat
   always_comb begin
      tok[0]            = '0;
      tok[0].valid      = accept;
      tok[0].cmd        = req_payload.cmd;
      tok[0].num        = req_payload.dev_number;
      tok[0].addr       = req_payload.net_address;
   end

   // Row of slot cells
   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      adt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(k)),
         .age_limit  (age_limit_ff),
         .tok_in     (tok[k]),
         .fill       (fill),
         .tok_out    (tok[k+1])
      );
   end

   assign tail = tok[TABLE_ENTRIES];

   // Learn miss with room: write the lowest free slot
   always_comb begin
      fill.en   = tail.valid && (tail.cmd == CMD_LEARN) && (tail.num != 16'd0) &&
                  !tail.matched && tail.free_found;
      fill.idx  = tail.free_idx;
      fill.num  = tail.num;
      fill.addr = tail.addr;
   end

   // Response decode from the token leaving the row
   always_comb begin
      rsp_in = '0;
      unique case (tail.cmd)
         CMD_LEARN: begin
            if (tail.num == 16'd0) begin
               rsp_in.status = ST_ZERO;
            end else if (tail.matched || tail.free_found) begin
               rsp_in.status = ST_OK;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         CMD_LOOKUP: begin
            if (tail.num == 16'd0) begin
               rsp_in.status = ST_ZERO;
            end else if (tail.matched) begin
               rsp_in.status        = ST_OK;
               rsp_in.found_address = tail.found_addr;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   // Control: busy flag, response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tail.valid;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (tail.valid) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   // Age limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
      end else if (csr_valid) begin
         age_limit_ff <= csr_data;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/adt_checker.sv
// ----------------------------------------------------------------------------
// adt_checker
// Port-level assertions for the address table, bound to the top level.
// ----------------------------------------------------------------------------
`include "aging_device_address_table_core_macros.svh"

module adt_checker
   import adt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // An accepted start beat makes the block busy
   `ADT_ASSERT_NXT(a_start_busy, start && !busy, busy, "accept did not raise busy")

   // A response shows only once the block is free again
   `ADT_ASSERT_IMP(a_rsp_idle, rsp_strobe, !busy, "response while busy")

   // Strobes never come back to back
   `ADT_ASSERT_NXT(a_rsp_single, rsp_strobe, !rsp_strobe, "strobe longer than a cycle")

   // No unused status code; an address comes only with a hit
   `ADT_ASSERT_IMP(a_status_code, rsp_strobe,
      (rsp_payload.status == ST_OK) || (rsp_payload.status == ST_MISS) ||
      (rsp_payload.status == ST_ZERO), "bad status")
   `ADT_ASSERT_IMP(a_addr_ok, rsp_strobe && (rsp_payload.found_address != 16'd0),
      rsp_payload.status == ST_OK, "address without hit")

endmodule

bind aging_device_address_table_core adt_checker u_adt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
